>>> hw/rtl/pru_pkg.sv
// Shared constants, types and the Paeth predictor for the PNG row unfilter.
`default_nettype none

package pru_pkg;

  localparam int DEF_MAX_ROW_BYTES   = 8192;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  localparam int CFG_AW = 3;

  // register indexes, taken from paddr[2]
  localparam logic REG_PIXEL_BYTES = 1'b0;
  localparam logic REG_ROW_BYTES   = 1'b1;

  // row filter codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // one item handed from the control stage to the reconstruction stage
  typedef struct packed {
    logic [2:0] filt;
    logic       first_row;
    logic       a_ok;
    logic       c_ok;
    logic       eor;
    logic       bad;
    logic [7:0] residual;
  } stage_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [9:0] da;
    logic [9:0] db;
    logic [9:0] dc;
    // da = |b - c|, db = |a - c|, dc = |a + b - 2c|
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = pa + pb;
    da = pa[9] ? 10'(-pa) : 10'(pa);
    db = pb[9] ? 10'(-pb) : 10'(pb);
    dc = pc[9] ? 10'(-pc) : 10'(pc);
    if (da <= db && da <= dc) begin
      paeth_pick = a;
    end else if (db <= dc) begin
      paeth_pick = b;
    end else begin
      paeth_pick = c;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pru_cfg.sv
// Configuration registers with APB access and range clamping.
`default_nettype none

module pru_cfg
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
  parameter int CW              = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [3:0]        pb_eff,
  output logic      [CW-1:0]     rb_eff
);

  logic [3:0]  pix_stride;
  logic [13:0] row_bytes;
  logic [CW-1:0] row_x;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_stride <= 4'd1;
      row_bytes  <= 14'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_PIXEL_BYTES: pix_stride <= pwdata[3:0];
        REG_ROW_BYTES:   row_bytes  <= pwdata[13:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PIXEL_BYTES: prdata = {28'd0, pix_stride};
      REG_ROW_BYTES:   prdata = {18'd0, row_bytes};
      default:         prdata = 32'd0;
    endcase
  end

  // clamp to the supported ranges
  always_comb begin
    if (pix_stride == 4'd0) begin
      pb_eff = 4'd1;
    end else if (pix_stride > 4'(MAX_PIXEL_BYTES)) begin
      pb_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pix_stride;
    end
  end

  assign row_x = CW'(row_bytes);

  always_comb begin
    if (row_x == '0) begin
      rb_eff = CW'(1);
    end else if (row_x > CW'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = row_x;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_line_store.sv
// Line store holding the row above, one read and one write port.
`default_nettype none

module pru_line_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_ctrl.sv
// Row control: type bytes, fault handling, column tracking and line store reads.
`default_nettype none

module pru_ctrl
  import pru_pkg::*;
#(
  parameter int CW = 14,
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tuser,
  input  wire logic [3:0]    pb_eff,
  input  wire logic [CW-1:0] rb_eff,
  input  wire logic          s1_room,
  output logic               s1_valid,
  output stage_t             s1,
  output logic      [AW-1:0] s1_col,
  output logic               rd_en,
  output logic      [AW-1:0] raddr
);

  logic          faulted;
  logic          awaiting;
  logic          first_row;
  logic [2:0]    row_filter;
  logic [CW-1:0] column;

  logic          accept;
  logic          faulted_e;
  logic          awaiting_e;
  logic          first_e;
  logic [CW-1:0] col_e;
  logic [CW-1:0] col_inc;
  logic          eor;
  logic          a_ok;
  logic          is_data;
  logic          is_bad;

  assign s_tready = !s1_valid || s1_room;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    faulted_e  = s_tuser ? 1'b0 : faulted;
    awaiting_e = s_tuser || awaiting;
    first_e    = s_tuser || first_row;
    col_e      = s_tuser ? '0 : column;
    col_inc    = col_e + CW'(1);
    eor        = col_inc >= rb_eff;
    a_ok       = col_e >= CW'(pb_eff);
    is_data    = !faulted_e && !awaiting_e;
    is_bad     = !faulted_e && awaiting_e && (s_tdata > {5'd0, FILT_PAETH});
  end

  assign rd_en = accept && is_data;
  assign raddr = col_e[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      faulted    <= 1'b0;
      awaiting   <= 1'b1;
      first_row  <= 1'b1;
      row_filter <= FILT_NONE;
      column     <= '0;
    end else if (accept) begin
      faulted   <= faulted_e;
      awaiting  <= awaiting_e;
      first_row <= first_e;
      column    <= col_e;
      if (!faulted_e) begin
        if (awaiting_e) begin
          if (is_bad) begin
            faulted <= 1'b1;
          end else begin
            row_filter <= s_tdata[2:0];
            awaiting   <= 1'b0;
            column     <= '0;
          end
        end else if (eor) begin
          column    <= '0;
          awaiting  <= 1'b1;
          first_row <= 1'b0;
        end else begin
          column <= col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && (is_data || is_bad)) begin
      s1_valid <= 1'b1;
    end else if (s1_room) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (is_data || is_bad)) begin
      s1.filt      <= row_filter;
      s1.first_row <= first_e;
      s1.a_ok      <= a_ok;
      s1.c_ok      <= a_ok && !first_e;
      s1.eor       <= eor;
      s1.bad       <= is_bad;
      s1.residual  <= s_tdata;
      s1_col       <= col_e[AW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_recon.sv
// Reconstruction stage: neighbor history, predictor, line store update, output register.
`default_nettype none

module pru_recon
  import pru_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
  parameter int AW              = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [3:0]    pb_eff,
  input  wire logic          s1_valid,
  input  wire stage_t        s1,
  input  wire logic [AW-1:0] s1_col,
  input  wire logic [7:0]    rdata,
  output logic               s1_room,
  output logic               wr_en,
  output logic      [AW-1:0] waddr,
  output logic      [7:0]    wdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic      [7:0]    m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  localparam int HIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0] left_hist  [0:MAX_PIXEL_BYTES-1];
  logic [7:0] above_hist [0:MAX_PIXEL_BYTES-1];

  logic [HIW-1:0] pb_idx;
  logic           advance;
  logic [7:0]     a;
  logic [7:0]     b;
  logic [7:0]     c;
  logic [8:0]     ab_sum;
  logic [7:0]     pred;
  logic [7:0]     y;

  assign s1_room = !m_tvalid || m_tready;
  assign advance = s1_valid && s1_room;
  assign pb_idx  = HIW'(pb_eff - 4'd1);

  always_comb begin
    a      = s1.a_ok ? left_hist[pb_idx] : 8'd0;
    b      = s1.first_row ? 8'd0 : rdata;
    c      = s1.c_ok ? above_hist[pb_idx] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s1.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
    y = s1.residual + pred;
  end

  assign wr_en = advance && !s1.bad;
  assign waddr = s1_col;
  assign wdata = y;

  // newest first; entries past the row start are masked by a_ok / c_ok
  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_hist[0]  <= y;
      above_hist[0] <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= left_hist[i-1];
        above_hist[i] <= above_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= s1.bad ? 8'd0 : y;
      m_tlast <= s1.bad ? 1'b0 : s1.eor;
      m_tuser <= s1.bad;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/png_row_unfilter.sv
// Top level of the streaming PNG row unfilter.
`default_nettype none

// Reverses the PNG per-row filters (None, Sub, Up, Average, Paeth) on a
// filtered byte stream, one byte per transfer. Each row opens with a filter
// type byte that yields no transfer on the output; each of the following
// row_bytes data bytes yields one reconstructed byte, with m_tlast on the
// last byte of the row. A type byte above 4 yields one transfer with m_tuser
// set and zero data, and the block then drops bytes until one arrives with
// s_tuser (start of image) set; s_tuser restarts the image on any byte.
// Rate: one byte per clock sustained while m_tready stays high, type bytes
// included. A data byte is loaded into the stage register at its input
// transfer, together with the line store read (one read port and one write
// port, MAX_ROW_BYTES deep); the predictor, which feeds back through the
// left-neighbor history, is captured in the output register, with m_tvalid
// high, once the stage can advance. The pipe holds two bytes; with m_tready
// low, s_tready drops once both are full.
// The line store needs no clearing pass after reset; in the first row of an
// image its read data is ignored.
// Configuration: the pixel stride in bytes at byte address 0
// (1..MAX_PIXEL_BYTES), row_bytes at byte address 4 (1..MAX_ROW_BYTES);
// out-of-range values are clamped. Write them only while the block is idle.

module png_row_unfilter
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // filtered byte stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] filtered_byte
  input  wire logic              s_tuser,   // [0] start_of_image
  // reconstructed byte stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [7:0]        m_tdata,   // [7:0] pixel_byte
  output logic                   m_tlast,   // end_of_row
  output logic                   m_tuser    // [0] bad_filter
);

  // column counter also compares against the 14-bit row_bytes register
  localparam int CLW = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW  = (CLW > 14) ? CLW : 14;
  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  logic [3:0]    pb_eff;
  logic [CW-1:0] rb_eff;
  logic          s1_valid;
  logic          s1_room;
  stage_t        s1;
  logic [AW-1:0] s1_col;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  pru_cfg #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .CW             (CW)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pb_eff (pb_eff),
    .rb_eff (rb_eff)
  );

  // track rows and columns, issue the line store read for each data byte
  pru_ctrl #(
    .CW(CW),
    .AW(AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .pb_eff  (pb_eff),
    .rb_eff  (rb_eff),
    .s1_room (s1_room),
    .s1_valid(s1_valid),
    .s1      (s1),
    .s1_col  (s1_col),
    .rd_en   (rd_en),
    .raddr   (raddr)
  );

  // row above: read when a byte enters the stage register, written back as bytes finish
  pru_line_store #(
    .DEPTH(MAX_ROW_BYTES),
    .AW   (AW)
  ) u_line_store (
    .clk  (clk),
    .rd_en(rd_en),
    .raddr(raddr),
    .rdata(rdata),
    .wr_en(wr_en),
    .waddr(waddr),
    .wdata(wdata)
  );

  // predict, add the residual and hold the result for the output transfer
  pru_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .AW             (AW)
  ) u_recon (
    .clk     (clk),
    .rst     (rst),
    .pb_eff  (pb_eff),
    .s1_valid(s1_valid),
    .s1      (s1),
    .s1_col  (s1_col),
    .rdata   (rdata),
    .s1_room (s1_room),
    .wr_en   (wr_en),
    .waddr   (waddr),
    .wdata   (wdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire
